// ----- sv/rqps_pkg.sv -----
// Shared types and constants for the ready queue policy select block.
// Holds the queue entry layout, operation, status and policy codes, FSM states
// and the command/status structs between controller and datapath. No dependencies.
package rqps_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int OCC_W       = 6;
    localparam int OP_W        = 3;
    localparam int STATUS_W    = 2;
    localparam int POLICY_W    = 2;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int IN_DATA_W   = 72;
    localparam int OUT_DATA_W  = 80;

    typedef struct packed {
        logic [31:0] vruntime;
        logic [15:0] length;
        logic [15:0] burst;
        logic [7:0]  thread;
    } entry_t;

    typedef enum logic [OP_W-1:0] {
        OP_INS_TAIL   = 3'd0,
        OP_INS_HEAD   = 3'd1,
        OP_REM_HEAD   = 3'd2,
        OP_REM_TAIL   = 3'd3,
        OP_REM_POLICY = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        RES_OK    = 2'd0,
        RES_EMPTY = 2'd1,
        RES_FULL  = 2'd2
    } status_t;

    typedef enum logic [POLICY_W-1:0] {
        POL_FCFS = 2'd0,
        POL_SJF  = 2'd1,
        POL_PRIO = 2'd2,
        POL_VRUN = 2'd3
    } policy_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_TAKE_HEAD,
        S_TAKE_TAIL,
        S_SCAN,
        S_PICK,
        S_SHIFT,
        S_EMIT
    } state_t;

    localparam logic [0:0] REG_POLICY = 1'b0;

    typedef struct packed {
        logic    cap_in;
        logic    clr_res;
        status_t res_status;
        logic    insert;
        logic    rd_head;
        logic    rd_tail;
        logic    scan_start;
        logic    scan_step;
        logic    take_rd;
        logic    take_pick;
        logic    shift_step;
        logic    inc_head;
        logic    dec_count;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic empty;
        logic full;
        logic fcfs;
        logic scan_last;
        logic shift_done;
    } dp_stat_t;

endpackage

// ----- sv/rqps_ctrl.sv -----
// Controller state machine of the ready queue policy select block.
// Sequences decode, reads, policy scan, compaction and result hand-off.
// Depends on rqps_pkg.
module rqps_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              out_free,
    output logic              out_load,
    input  rqps_pkg::dp_stat_t stat,
    output rqps_pkg::cmd_t     cmd
);

    rqps_pkg::state_t state_reg;
    rqps_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rqps_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rqps_pkg::S_IDLE: begin
                if (s_valid) begin
                    state_next = rqps_pkg::S_DECODE;
                end
            end
            rqps_pkg::S_DECODE: begin
                case (stat.op)
                    rqps_pkg::OP_REM_HEAD: begin
                        state_next = stat.empty ? rqps_pkg::S_EMIT : rqps_pkg::S_TAKE_HEAD;
                    end
                    rqps_pkg::OP_REM_TAIL: begin
                        state_next = stat.empty ? rqps_pkg::S_EMIT : rqps_pkg::S_TAKE_TAIL;
                    end
                    rqps_pkg::OP_REM_POLICY: begin
                        if (stat.empty) begin
                            state_next = rqps_pkg::S_EMIT;
                        end else if (stat.fcfs) begin
                            state_next = rqps_pkg::S_TAKE_HEAD;
                        end else begin
                            state_next = rqps_pkg::S_SCAN;
                        end
                    end
                    default: begin
                        state_next = rqps_pkg::S_EMIT;
                    end
                endcase
            end
            rqps_pkg::S_TAKE_HEAD: state_next = rqps_pkg::S_EMIT;
            rqps_pkg::S_TAKE_TAIL: state_next = rqps_pkg::S_EMIT;
            rqps_pkg::S_SCAN: begin
                if (stat.scan_last) begin
                    state_next = rqps_pkg::S_PICK;
                end
            end
            rqps_pkg::S_PICK: state_next = rqps_pkg::S_SHIFT;
            rqps_pkg::S_SHIFT: begin
                if (stat.shift_done) begin
                    state_next = rqps_pkg::S_EMIT;
                end
            end
            rqps_pkg::S_EMIT: begin
                if (out_free) begin
                    state_next = rqps_pkg::S_IDLE;
                end
            end
            default: state_next = rqps_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_ready  = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            rqps_pkg::S_IDLE: begin
                s_ready    = 1'b1;
                cmd.cap_in = s_valid;
            end
            rqps_pkg::S_DECODE: begin
                cmd.clr_res = 1'b1;
                case (stat.op)
                    rqps_pkg::OP_INS_TAIL, rqps_pkg::OP_INS_HEAD: begin
                        if (stat.full) begin
                            cmd.res_status = rqps_pkg::RES_FULL;
                        end else begin
                            cmd.insert = 1'b1;
                        end
                    end
                    rqps_pkg::OP_REM_HEAD: begin
                        if (stat.empty) begin
                            cmd.res_status = rqps_pkg::RES_EMPTY;
                        end else begin
                            cmd.rd_head = 1'b1;
                        end
                    end
                    rqps_pkg::OP_REM_TAIL: begin
                        if (stat.empty) begin
                            cmd.res_status = rqps_pkg::RES_EMPTY;
                        end else begin
                            cmd.rd_tail = 1'b1;
                        end
                    end
                    rqps_pkg::OP_REM_POLICY: begin
                        if (stat.empty) begin
                            cmd.res_status = rqps_pkg::RES_EMPTY;
                        end else if (stat.fcfs) begin
                            cmd.rd_head = 1'b1;
                        end else begin
                            cmd.scan_start = 1'b1;
                        end
                    end
                    default: begin
                        cmd.res_status = rqps_pkg::RES_OK;
                    end
                endcase
            end
            rqps_pkg::S_TAKE_HEAD: begin
                cmd.take_rd   = 1'b1;
                cmd.inc_head  = 1'b1;
                cmd.dec_count = 1'b1;
            end
            rqps_pkg::S_TAKE_TAIL: begin
                cmd.take_rd   = 1'b1;
                cmd.dec_count = 1'b1;
            end
            rqps_pkg::S_SCAN: begin
                cmd.scan_step = 1'b1;
            end
            rqps_pkg::S_PICK: begin
                cmd.take_pick = 1'b1;
            end
            rqps_pkg::S_SHIFT: begin
                cmd.shift_step = 1'b1;
                cmd.dec_count  = stat.shift_done;
            end
            rqps_pkg::S_EMIT: begin
                out_load = out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- sv/rqps_dp.sv -----
// Datapath of the ready queue policy select block: circular entry memory,
// head pointer and count, policy scan compare, compaction and result register.
// Depends on rqps_pkg; driven by rqps_ctrl commands.
module rqps_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  rqps_pkg::cmd_t                    cmd,
    output rqps_pkg::dp_stat_t                stat,
    input  rqps_pkg::policy_t                 policy,
    input  logic [rqps_pkg::OP_W-1:0]         in_op,
    input  rqps_pkg::entry_t                  in_entry,
    output rqps_pkg::status_t                 res_status,
    output rqps_pkg::entry_t                  res_entry,
    output logic [rqps_pkg::CNT_W-1:0]        count
);

    localparam int PW = rqps_pkg::PTR_W;
    localparam int CW = rqps_pkg::CNT_W;

    function automatic logic [PW-1:0] phys(input logic [PW-1:0] base, input logic [PW-1:0] pos);
        logic [PW:0] sum;
        sum = {1'b0, base} + {1'b0, pos};
        if (sum >= (PW+1)'(rqps_pkg::QUEUE_DEPTH)) begin
            sum = sum - (PW+1)'(rqps_pkg::QUEUE_DEPTH);
        end
        return sum[PW-1:0];
    endfunction

    rqps_pkg::entry_t mem [rqps_pkg::QUEUE_DEPTH];

    rqps_pkg::op_t     op_reg;
    rqps_pkg::entry_t  in_reg;
    logic [PW-1:0]     head_reg, head_next;
    logic [CW-1:0]     count_reg, count_next;
    rqps_pkg::entry_t  rd_data_reg;
    logic              rd_valid_reg;
    logic [PW-1:0]     rd_pos_reg;
    logic [CW-1:0]     scan_idx_reg, scan_idx_next;
    rqps_pkg::entry_t  pick_reg, pick_next;
    logic [PW-1:0]     pick_pos_reg, pick_pos_next;
    logic [CW-1:0]     shift_src_reg, shift_src_next;
    rqps_pkg::status_t res_status_reg, res_status_next;
    rqps_pkg::entry_t  res_entry_reg, res_entry_next;

    logic              rd_en;
    logic [PW-1:0]     rd_pos;
    logic              wr_en;
    logic [PW-1:0]     wr_addr;
    rqps_pkg::entry_t  wr_data;
    logic [PW-1:0]     head_dec;
    logic [PW-1:0]     head_inc;
    logic              take;

    always_comb begin
        head_dec = (head_reg == '0) ? PW'(rqps_pkg::QUEUE_DEPTH - 1) : head_reg - 1'b1;
        head_inc = phys(head_reg, PW'(1));
    end

    always_comb begin
        case (policy)
            rqps_pkg::POL_SJF: take = (rd_data_reg.length <= pick_reg.length) &&
                                      (rd_data_reg.thread != pick_reg.thread);
            rqps_pkg::POL_PRIO: take = rd_data_reg.thread < pick_reg.thread;
            rqps_pkg::POL_VRUN: take = rd_data_reg.vruntime < pick_reg.vruntime;
            default: take = 1'b0;
        endcase
    end

    always_comb begin
        rd_en  = 1'b0;
        rd_pos = '0;
        if (cmd.rd_head || cmd.scan_start) begin
            rd_en = 1'b1;
        end else if (cmd.rd_tail) begin
            rd_en  = 1'b1;
            rd_pos = PW'(count_reg - 1'b1);
        end else if (cmd.scan_step && (scan_idx_reg < count_reg)) begin
            rd_en  = 1'b1;
            rd_pos = scan_idx_reg[PW-1:0];
        end else if (cmd.shift_step && (shift_src_reg < count_reg)) begin
            rd_en  = 1'b1;
            rd_pos = shift_src_reg[PW-1:0];
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = in_reg;
        if (cmd.insert) begin
            wr_en   = 1'b1;
            wr_addr = (op_reg == rqps_pkg::OP_INS_HEAD) ? head_dec
                                                        : phys(head_reg, count_reg[PW-1:0]);
        end else if (cmd.shift_step && rd_valid_reg) begin
            wr_en   = 1'b1;
            wr_addr = phys(head_reg, rd_pos_reg - 1'b1);
            wr_data = rd_data_reg;
        end
    end

    always_comb begin
        head_next       = head_reg;
        count_next      = count_reg;
        scan_idx_next   = scan_idx_reg;
        pick_next       = pick_reg;
        pick_pos_next   = pick_pos_reg;
        shift_src_next  = shift_src_reg;
        res_status_next = res_status_reg;
        res_entry_next  = res_entry_reg;
        if (cmd.insert) begin
            count_next = count_reg + 1'b1;
            if (op_reg == rqps_pkg::OP_INS_HEAD) begin
                head_next = head_dec;
            end
        end
        if (cmd.inc_head) begin
            head_next = head_inc;
        end
        if (cmd.dec_count) begin
            count_next = count_reg - 1'b1;
        end
        if (cmd.scan_start) begin
            scan_idx_next = CW'(1);
        end
        if (cmd.scan_step) begin
            if (scan_idx_reg < count_reg) begin
                scan_idx_next = scan_idx_reg + 1'b1;
            end
            if ((rd_pos_reg == '0) || take) begin
                pick_next     = rd_data_reg;
                pick_pos_next = rd_pos_reg;
            end
        end
        if (cmd.shift_step && (shift_src_reg < count_reg)) begin
            shift_src_next = shift_src_reg + 1'b1;
        end
        if (cmd.clr_res) begin
            res_status_next = cmd.res_status;
            res_entry_next  = '0;
        end
        if (cmd.take_rd) begin
            res_entry_next = rd_data_reg;
        end
        if (cmd.take_pick) begin
            res_entry_next = pick_reg;
            shift_src_next = CW'(pick_pos_reg) + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg     <= '0;
            count_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            head_reg     <= head_next;
            count_reg    <= count_next;
            rd_valid_reg <= rd_en;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.cap_in) begin
            op_reg <= rqps_pkg::op_t'(in_op);
            in_reg <= in_entry;
        end
        rd_pos_reg     <= rd_pos;
        scan_idx_reg   <= scan_idx_next;
        pick_reg       <= pick_next;
        pick_pos_reg   <= pick_pos_next;
        shift_src_reg  <= shift_src_next;
        res_status_reg <= res_status_next;
        res_entry_reg  <= res_entry_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[phys(head_reg, rd_pos)];
        end
    end

    always_comb begin
        stat.op         = op_reg;
        stat.empty      = (count_reg == '0);
        stat.full       = (count_reg >= CW'(rqps_pkg::QUEUE_DEPTH));
        stat.fcfs       = (policy == rqps_pkg::POL_FCFS);
        stat.scan_last  = (scan_idx_reg == count_reg);
        stat.shift_done = (shift_src_reg >= count_reg) && !rd_valid_reg;
    end

    assign res_status = res_status_reg;
    assign res_entry  = res_entry_reg;
    assign count      = count_reg;

endmodule

// ----- sv/ready_queue_policy_select_core.sv -----
// Top level of the ready queue policy select block: stream channels, APB
// register port, output register and assertions.
// Depends on rqps_pkg, rqps_ctrl and rqps_dp.
//
// One input beat carries an operation in s_axis_tuser and a burst in
// s_axis_tdata; every accepted beat produces exactly one result beat on the
// m_axis channel with a status in m_axis_tuser and the removed burst plus the
// queue occupancy in m_axis_tdata. Items are processed one at a time, and the
// next beat is accepted in the cycle after a result loads.
// Inserts and failed operations go from decode straight to the emit state; head
// and tail removals and first come first served removals pass a take state first.
// A policy removal scans all N queued bursts, one cycle per entry, through the
// single read port of the entry memory, picks one, then moves each later
// entry down one position, one cycle per later entry, to close the
// gap. s_axis_tready is high only while the controller is idle; a new beat is
// accepted while the previous result still waits in the output register, and
// a stalled receiver holds the next result in the controller until the
// output register frees. Reset empties the queue, clears the policy to first
// come first served and drops any pending result; entry storage is not cleared.
// Write the policy register through APB only while idle; the core does not check.
module ready_queue_policy_select_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // thread_index[7:0], burst_index[23:8], burst_length[39:24], virtual_runtime[71:40]
    input  logic [rqps_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // operation[2:0]
    input  logic [rqps_pkg::OP_W-1:0]            s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // out_thread[7:0], out_burst[23:8], out_length[39:24], out_vruntime[71:40],
    // occupancy[77:72], zero[79:78]
    output logic [rqps_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // status[1:0]
    output logic [rqps_pkg::STATUS_W-1:0]        m_axis_tuser,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [rqps_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [rqps_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [rqps_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready
);

    rqps_pkg::cmd_t              cmd;
    rqps_pkg::dp_stat_t          stat;
    rqps_pkg::policy_t           policy_reg;
    rqps_pkg::status_t           res_status;
    rqps_pkg::entry_t            res_entry;
    logic [rqps_pkg::CNT_W-1:0]  count;
    logic                        out_free;
    logic                        out_load;
    logic                        m_valid_reg, m_valid_next;
    logic [rqps_pkg::OUT_DATA_W-1:0] m_data_reg;
    logic [rqps_pkg::STATUS_W-1:0]   m_user_reg;
    logic                        reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == rqps_pkg::REG_POLICY);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg <= rqps_pkg::POL_FCFS;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            policy_reg <= rqps_pkg::policy_t'(pwdata[rqps_pkg::POLICY_W-1:0]);
        end
    end

    assign prdata = reg_sel ? {{(rqps_pkg::APB_DATA_W-rqps_pkg::POLICY_W){1'b0}}, policy_reg}
                            : '0;

    rqps_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_axis_tvalid),
        .s_ready  (s_axis_tready),
        .out_free (out_free),
        .out_load (out_load),
        .stat     (stat),
        .cmd      (cmd)
    );

    rqps_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .policy     (policy_reg),
        .in_op      (s_axis_tuser),
        .in_entry   (rqps_pkg::entry_t'(s_axis_tdata)),
        .res_status (res_status),
        .res_entry  (res_entry),
        .count      (count)
    );

    assign out_free = !m_valid_reg || m_axis_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= {2'b00, rqps_pkg::OCC_W'(count), res_entry};
            m_user_reg <= res_status;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[77:72] <= rqps_pkg::OCC_W'(rqps_pkg::QUEUE_DEPTH)))
        else $error("occupancy exceeds queue depth");

    a_full_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (m_axis_tuser == rqps_pkg::RES_FULL)) |->
        (m_axis_tdata[77:72] == rqps_pkg::OCC_W'(rqps_pkg::QUEUE_DEPTH)))
        else $error("full status with queue not full");

    a_empty_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (m_axis_tuser == rqps_pkg::RES_EMPTY)) |->
        (m_axis_tdata[77:0] == '0))
        else $error("empty status with data or nonzero occupancy");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("new beat accepted while an item is in progress");

endmodule
